// ===== rtl/dtp_pkg.sv =====
// Package for the debounced trigger pad controller.
// Holds request, LED, event and register index codes and the debouncer status type.
// No dependencies.
`timescale 1ns / 1ps

package dtp_pkg;

    localparam logic [1:0] REQ_SAMPLE     = 2'd0;
    localparam logic [1:0] REQ_TICK       = 2'd1;
    localparam logic [1:0] REQ_ACTIVATE   = 2'd2;
    localparam logic [1:0] REQ_DEACTIVATE = 2'd3;

    localparam logic [1:0] LED_OFF  = 2'd0;
    localparam logic [1:0] LED_BLUE = 2'd1;
    localparam logic [1:0] LED_RED  = 2'd2;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_TRIGGERED = 2'd1;
    localparam logic [1:0] EV_ERROR     = 2'd2;

    localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [1:0] CFG_FLASH    = 2'd1;

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd5;
    localparam logic [15:0] FLASH_RESET    = 16'd1000;

    typedef struct packed {
        logic pressed;
        logic press_edge;
        logic release_edge;
    } t_deb_status;

endpackage

// ===== rtl/dtp_debounce.sv =====
// Sample debouncer: accepts a level change after a run of equal samples.
// Depends on dtp_pkg for the status type.
`timescale 1ns / 1ps

module dtp_debounce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample,
    input  logic                 i_raw,
    input  logic [7:0]           i_samples,
    output dtp_pkg::t_deb_status o_status
);
    import dtp_pkg::*;

    logic       r_last_raw;
    logic [7:0] r_count;
    logic       r_debounced;
    logic [7:0] n_count;
    logic       w_change;

    always_comb begin
        if (i_raw == r_last_raw) begin
            n_count = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
        end else begin
            n_count = 8'd1;
        end
        w_change = i_sample && (n_count >= i_samples) && (i_raw != r_debounced);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw  <= 1'b0;
            r_count     <= 8'd0;
            r_debounced <= 1'b0;
        end else if (i_sample) begin
            r_last_raw <= i_raw;
            r_count    <= n_count;
            if (w_change) begin
                r_debounced <= i_raw;
            end
        end
    end

    assign o_status.pressed      = w_change ? i_raw : r_debounced;
    assign o_status.press_edge   = w_change && i_raw;
    assign o_status.release_edge = w_change && !i_raw;

endmodule

// ===== rtl/debounced_trigger_pad_controller.sv =====
// Top level of the debounced trigger pad controller: handshakes, pad state, result register.
// Depends on dtp_pkg and dtp_debounce.
//
//  channel | direction | handshake             | word
//  in      | input     | i_in_valid/o_in_stall | req_type, raw_level, now_ms
//  out     | output    | o_out_valid/i_out_stall | pressed .. event_code
//  cfg     | input     | i_cfg_valid/o_cfg_ready | index, data
//
// One word per cycle while the output is not stalled; each result is registered and
// appears in the cycle after its word is accepted. The single result register sets the
// rate: a new word enters whenever that register is empty or being taken in the same cycle.
// Synchronous active-low reset clears control state and loads register defaults, not the
// result data registers. A stall on the output holds the result and stalls the input.
`timescale 1ns / 1ps

module debounced_trigger_pad_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic        i_raw_level,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_pressed,
    output logic        o_press_edge,
    output logic        o_release_edge,
    output logic        o_armed,
    output logic        o_hit,
    output logic [1:0]  o_led_color,
    output logic [1:0]  o_event_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import dtp_pkg::*;

    logic [7:0]  r_debounce_samples;
    logic [15:0] r_flash_duration;
    logic        r_press_pending;
    logic        r_armed;
    logic        r_hit;
    logic        r_flash_running;
    logic [31:0] r_flash_deadline;
    logic        r_blink;
    logic        r_out_valid;
    logic        r_pressed;
    logic        r_press_edge;
    logic        r_release_edge;
    logic        r_armed_out;
    logic        r_hit_out;
    logic [1:0]  r_led;
    logic [1:0]  r_event;

    logic        n_press_pending;
    logic        n_armed;
    logic        n_hit;
    logic        n_flash_running;
    logic [31:0] n_flash_deadline;
    logic        n_blink;
    logic [1:0]  n_led;
    logic [1:0]  n_event;
    logic [31:0] w_elapsed;
    logic        w_accept;
    logic        w_sample;
    t_deb_status w_deb;

    function automatic logic [1:0] led_now(input logic armed, input logic hit,
                                           input logic flash, input logic blink);
        if (armed && !hit) begin
            return LED_BLUE;
        end
        if (!armed && hit && flash && blink) begin
            return LED_RED;
        end
        return LED_OFF;
    endfunction

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_sample    = w_accept && (i_req_type == REQ_SAMPLE);
    assign o_cfg_ready = 1'b1;

    dtp_debounce u_debounce (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (w_sample),
        .i_raw     (i_raw_level),
        .i_samples (r_debounce_samples),
        .o_status  (w_deb)
    );

    always_comb begin
        n_press_pending  = r_press_pending;
        n_armed          = r_armed;
        n_hit            = r_hit;
        n_flash_running  = r_flash_running;
        n_flash_deadline = r_flash_deadline;
        n_blink          = r_blink;
        n_event          = EV_NONE;
        n_led            = LED_OFF;
        w_elapsed        = '0;
        unique case (i_req_type)
            REQ_SAMPLE: begin
                if (w_deb.press_edge) begin
                    n_press_pending = 1'b1;
                end
                n_led = led_now(r_armed, r_hit, r_flash_running, r_blink);
            end
            REQ_TICK: begin
                if (r_press_pending) begin
                    n_press_pending = 1'b0;
                    if (r_armed) begin
                        if (!r_hit) begin
                            n_hit   = 1'b1;
                            n_event = EV_TRIGGERED;
                        end
                    end else begin
                        n_hit            = 1'b1;
                        n_flash_running  = 1'b1;
                        n_flash_deadline = i_now_ms + {16'd0, r_flash_duration};
                    end
                end
                w_elapsed = i_now_ms - n_flash_deadline;
                if (!n_armed && n_hit && n_flash_running && !w_elapsed[31]) begin
                    n_hit           = 1'b0;
                    n_flash_running = 1'b0;
                end
                if (n_armed && !n_hit) begin
                    n_led = LED_BLUE;
                end else if (!n_armed && n_hit && n_flash_running) begin
                    n_blink = !r_blink;
                    n_led   = n_blink ? LED_RED : LED_OFF;
                end else begin
                    n_led = LED_OFF;
                end
            end
            REQ_ACTIVATE: begin
                if (r_hit) begin
                    n_event = EV_ERROR;
                end else begin
                    n_armed         = 1'b1;
                    n_flash_running = 1'b0;
                end
                n_led = led_now(n_armed, n_hit, n_flash_running, r_blink);
            end
            REQ_DEACTIVATE: begin
                n_armed         = 1'b0;
                n_hit           = 1'b0;
                n_flash_running = 1'b0;
                n_led = led_now(n_armed, n_hit, n_flash_running, r_blink);
            end
            default: begin
                n_led = LED_OFF;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_samples <= DEBOUNCE_RESET;
            r_flash_duration   <= FLASH_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_DEBOUNCE) begin
                r_debounce_samples <= i_cfg_data[7:0];
            end else if (i_cfg_index == CFG_FLASH) begin
                r_flash_duration <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_pending  <= 1'b0;
            r_armed          <= 1'b0;
            r_hit            <= 1'b0;
            r_flash_running  <= 1'b0;
            r_flash_deadline <= '0;
            r_blink          <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (w_accept) begin
                r_press_pending  <= n_press_pending;
                r_armed          <= n_armed;
                r_hit            <= n_hit;
                r_flash_running  <= n_flash_running;
                r_flash_deadline <= n_flash_deadline;
                r_blink          <= n_blink;
                r_out_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pressed      <= w_deb.pressed;
            r_press_edge   <= w_sample && w_deb.press_edge;
            r_release_edge <= w_sample && w_deb.release_edge;
            r_armed_out    <= n_armed;
            r_hit_out      <= n_hit;
            r_led          <= n_led;
            r_event        <= n_event;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pressed      = r_pressed;
    assign o_press_edge   = r_press_edge;
    assign o_release_edge = r_release_edge;
    assign o_armed        = r_armed_out;
    assign o_hit          = r_hit_out;
    assign o_led_color    = r_led;
    assign o_event_code   = r_event;

endmodule
